### hdl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants, codes and controller/datapath interface types for the
// RPN integer calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DEPTH    = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_DIVZERO  = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH_ACC,
        S_OPCHK,
        S_RD_B,
        S_RD_A,
        S_EXEC,
        S_DIV,
        S_PUSH_RES,
        S_EMIT,
        S_HALT
    } state_t;

    // what the pending result carries
    typedef enum logic [1:0] {
        EMIT_VALUE,
        EMIT_ERROR,
        EMIT_DEPTH,
        EMIT_EMPTY
    } emit_t;

    typedef enum logic [1:0] {
        RD_TOP,
        RD_SECOND,
        RD_BOTTOM
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    acc_digit;
        logic    push;
        logic    push_res;
        logic    pop2;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    load_b;
        logic    load_a;
        logic    exec;
        logic    div_start;
        logic    res_from_div;
        logic    out_load;
        emit_t   out_kind;
        logic    line_clear;
    } dp_cmd_t;

    typedef struct packed {
        logic eol;
        logic is_digit;
        logic pending;
        logic is_op;
        logic is_div;
        logic b_zero;
        logic cnt_lt2;
        logic cnt_eq1;
        logic err_nz;
        logic div_done;
    } dp_stat_t;

endpackage

### hdl/rpn_divider.sv
// ----------------------------------------------------------------------------
// rpn_divider
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rpn_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rpn_pkg::DATA_W-1:0] dividend,
    input  logic [rpn_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [rpn_pkg::DATA_W-1:0] quotient
);
    import rpn_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    q_reg, q_next;
    logic [DATA_W-1:0]    r_reg, r_next;
    logic [DATA_W-1:0]    d_reg, d_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W:0]      r_shift;
    logic [DATA_W:0]      diff;

    assign r_shift = {r_reg, q_reg[DATA_W-1]};
    assign diff    = r_shift - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            d_next    = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            r_next    = '0;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            // restoring step: dividend shifts out of q as quotient bits shift in
            if (!diff[DATA_W])
            begin
                r_next = diff[DATA_W-1:0];
                q_next = {q_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_shift[DATA_W-1:0];
                q_next = {q_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule

### hdl/rpn_datapath.sv
// ----------------------------------------------------------------------------
// rpn_datapath
// Value stack memory, number accumulator, operand registers, arithmetic,
// line error record and the result output register.
// ----------------------------------------------------------------------------
module rpn_datapath
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rpn_pkg::dp_cmd_t           cmd,
    output rpn_pkg::dp_stat_t          stat,
    input  logic [rpn_pkg::CHAR_W-1:0] char_code,
    input  logic                       end_of_line,
    output logic [rpn_pkg::DATA_W-1:0] value,
    output rpn_pkg::status_t           status
);
    import rpn_pkg::*;

    logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic [PTR_W-1:0]    rd_addr;
    logic [CNT_W-1:0]    cnt_m1, cnt_m2;

    logic [CHAR_W-1:0]   char_reg;
    logic                eol_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic                pend_reg, pend_next;
    status_t             err_reg, err_next;
    logic [DATA_W-1:0]   a_reg, b_reg;
    logic [DATA_W-1:0]   res_reg;
    logic [DATA_W-1:0]   value_reg;
    status_t             status_reg;

    logic                full;
    logic                wr_en;
    logic [DATA_W-1:0]   wr_data;
    logic [DIGIT_W-1:0]  digit;
    logic [DATA_W-1:0]   prod;
    logic                div_done;
    logic [DATA_W-1:0]   div_q;
    logic                note_err;
    status_t             note_code;

    rpn_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign full    = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign wr_en   = cmd.push && !full;
    assign wr_data = cmd.push_res ? res_reg : acc_reg;
    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign cnt_m2  = cnt_reg - CNT_W'(2);
    assign digit   = DIGIT_W'(char_reg - CH_ZERO);
    // only the low word of the product is kept
    assign prod    = a_reg * b_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_TOP:    rd_addr = cnt_m1[PTR_W-1:0];
            RD_SECOND: rd_addr = cnt_m2[PTR_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[cnt_reg[PTR_W-1:0]] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= stack_mem[rd_addr];
    end

    always_comb
    begin
        note_err  = 1'b0;
        note_code = ST_OK;
        if (cmd.push && full)
        begin
            note_err  = 1'b1;
            note_code = ST_OVERFLOW;
        end
        else if (cmd.exec && (char_reg == CH_SLASH) && (b_reg == '0))
        begin
            note_err  = 1'b1;
            note_code = ST_DIVZERO;
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        err_next  = err_reg;
        if (cmd.line_clear)
        begin
            cnt_next  = '0;
            acc_next  = '0;
            pend_next = 1'b0;
            err_next  = ST_OK;
        end
        else
        begin
            if (cmd.acc_digit)
            begin
                // acc * 10 as two shifts
                acc_next  = (acc_reg << 3) + (acc_reg << 1) + DATA_W'(digit);
                pend_next = 1'b1;
            end
            if (cmd.push && !cmd.push_res)
            begin
                acc_next  = '0;
                pend_next = 1'b0;
            end
            if (cmd.pop2)
                cnt_next = cnt_m2;
            else if (wr_en)
                cnt_next = cnt_reg + CNT_W'(1);
            // first error of the line wins
            if (note_err && (err_reg == ST_OK))
                err_next = note_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            acc_reg  <= '0;
            pend_reg <= 1'b0;
            err_reg  <= ST_OK;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            char_reg <= char_code;
            eol_reg  <= end_of_line;
        end
        if (cmd.load_b)
            b_reg <= rd_data_reg;
        if (cmd.load_a)
            a_reg <= rd_data_reg;
        if (cmd.exec)
        begin
            case (char_reg)
                CH_PLUS:  res_reg <= a_reg + b_reg;
                CH_MINUS: res_reg <= a_reg - b_reg;
                CH_STAR:  res_reg <= prod;
                default:  res_reg <= '0;
            endcase
        end
        else if (cmd.res_from_div)
            res_reg <= div_q;
        if (cmd.out_load)
        begin
            case (cmd.out_kind)
                EMIT_VALUE:
                begin
                    value_reg  <= rd_data_reg;
                    status_reg <= ST_OK;
                end
                EMIT_ERROR:
                begin
                    value_reg  <= '0;
                    status_reg <= err_reg;
                end
                EMIT_DEPTH:
                begin
                    value_reg  <= '0;
                    status_reg <= ST_DEPTH;
                end
                default:
                begin
                    value_reg  <= '0;
                    status_reg <= ST_EMPTY;
                end
            endcase
        end
    end

    always_comb
    begin
        stat.eol      = eol_reg;
        stat.is_digit = char_reg inside {[CH_ZERO:CH_NINE]};
        stat.pending  = pend_reg;
        stat.is_op    = char_reg inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
        stat.is_div   = (char_reg == CH_SLASH);
        stat.b_zero   = (b_reg == '0);
        stat.cnt_lt2  = (cnt_reg < CNT_W'(2));
        stat.cnt_eq1  = (cnt_reg == CNT_W'(1));
        stat.err_nz   = (err_reg != ST_OK);
        stat.div_done = div_done;
    end

    assign value  = value_reg;
    assign status = status_reg;

endmodule

### hdl/rpn_controller.sv
// ----------------------------------------------------------------------------
// rpn_controller
// Sequencer for the calculator: decodes each captured character, steps the
// stack reads and arithmetic, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module rpn_controller
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rpn_pkg::dp_stat_t stat,
    output rpn_pkg::dp_cmd_t  cmd
);
    import rpn_pkg::*;

    state_t state_reg, state_next;
    emit_t  emit_reg, emit_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        emit_next  = emit_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
                if (stat.eol)
                begin
                    state_next = S_EMIT;
                    if (stat.err_nz)
                        emit_next = EMIT_ERROR;
                    else if (stat.cnt_eq1)
                        emit_next = EMIT_VALUE;
                    else
                        emit_next = EMIT_DEPTH;
                end
                else if (stat.is_digit)
                    state_next = S_IDLE;
                else if (stat.pending)
                    state_next = S_PUSH_ACC;
                else
                    state_next = S_OPCHK;
            S_PUSH_ACC:
                state_next = S_OPCHK;
            S_OPCHK:
                if (!stat.is_op)
                    state_next = S_IDLE;
                else if (stat.cnt_lt2)
                begin
                    state_next = S_EMIT;
                    emit_next  = EMIT_EMPTY;
                end
                else
                    state_next = S_RD_B;
            S_RD_B:
                state_next = S_RD_A;
            S_RD_A:
                state_next = S_EXEC;
            S_EXEC:
                if (stat.is_div && !stat.b_zero)
                    state_next = S_DIV;
                else
                    state_next = S_PUSH_RES;
            S_DIV:
                if (stat.div_done)
                    state_next = S_PUSH_RES;
            S_PUSH_RES:
                state_next = S_IDLE;
            S_EMIT:
                if (out_free)
                    state_next = (emit_reg == EMIT_EMPTY) ? S_HALT : S_IDLE;
            S_HALT:
                state_next = S_HALT;
            default:
                state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = RD_TOP;
        cmd.out_kind   = emit_reg;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DECODE:
                if (stat.eol)
                begin
                    // bottom entry, used only when the depth is one
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_BOTTOM;
                end
                else if (stat.is_digit)
                    cmd.acc_digit = 1'b1;
            S_PUSH_ACC:
                cmd.push = 1'b1;
            S_OPCHK:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_TOP;
            end
            S_RD_B:
            begin
                cmd.load_b = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SECOND;
            end
            S_RD_A:
                cmd.load_a = 1'b1;
            S_EXEC:
            begin
                cmd.exec      = 1'b1;
                cmd.pop2      = 1'b1;
                cmd.div_start = stat.is_div && !stat.b_zero;
            end
            S_DIV:
                cmd.res_from_div = stat.div_done;
            S_PUSH_RES:
            begin
                cmd.push     = 1'b1;
                cmd.push_res = 1'b1;
            end
            S_EMIT:
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.line_clear = (emit_reg != EMIT_EMPTY);
                    out_valid_next = 1'b1;
                end
            S_HALT:
                in_ready = 1'b1;    // transactions are taken and dropped
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            emit_reg      <= EMIT_DEPTH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/rpn_integer_calculator.sv
// ----------------------------------------------------------------------------
// rpn_integer_calculator
// Reverse Polish integer calculator fed one character per transaction.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): char_code plus end_of_line. Digits build
// a 32-bit wrapping number; any other character pushes it; + - * / pop two
// values and push (second op top). end_of_line asks for the line result.
// Output channel (out_valid/out_ready): value and status, one result per
// line end, or one when an operator finds fewer than two values.
// Each transaction runs to its end before the next one is accepted: a digit
// is decoded and accumulated; any other character first pushes a pending
// number, then is checked; + - * / then read both operands, execute and
// push, / waiting on the divider unless the divisor is zero; end of line
// goes to the emit state, which loads the result into the output register.
// Stack reads go through the single registered read port of the stack
// memory, so the two operands are read one after the other.
// A finished result sits in the output register while the next transaction
// is taken; a stalled receiver holds the block only when another result is
// ready to be loaded. Reset clears the line state and empties the stack.
// After a short-stack error the block keeps accepting transactions but
// ignores them until reset.
// ----------------------------------------------------------------------------
module rpn_integer_calculator
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rpn_pkg::CHAR_W-1:0] char_code,
    input  logic                       end_of_line,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rpn_pkg::DATA_W-1:0] value,
    output rpn_pkg::status_t           status
);
    import rpn_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rpn_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rpn_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .char_code   (char_code),
        .end_of_line (end_of_line),
        .value       (value),
        .status      (status)
    );

endmodule

### hdl/rpn_checker.sv
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks for the RPN calculator, bound to the top level.
// ----------------------------------------------------------------------------
module rpn_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [rpn_pkg::DATA_W-1:0] value,
    input rpn_pkg::status_t           status
);
    import rpn_pkg::*;

    // a waiting input transaction is not withdrawn
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input withdrawn before acceptance");

    // a waiting result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
        else $error("result changed while stalled");

    // only an ok result carries a value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> value == '0)
        else $error("error result with non-zero value");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_DEPTH) || (status == ST_EMPTY)
                      || (status == ST_DIVZERO) || (status == ST_OVERFLOW))
        else $error("status code out of range");

    // nothing follows a short-stack halt
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (status == ST_EMPTY) |=> !out_valid)
        else $error("result after halt");

endmodule

bind rpn_integer_calculator rpn_checker u_rpn_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
);
